### hdl/iat_pkg.sv
// Shared types, register indexes and constants of the ignition advance timer.
package iat_pkg;

    localparam int TABLE_LEN_DEF = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int DIV_NUM_W     = 48;
    localparam int DIV_DEN_W     = 32;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_RPM_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADV_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADV_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTV  = 3'd5;

    localparam logic [15:0] PULSE_LEN_RST = 16'd2000;
    localparam logic [15:0] MIN_INTV_RST  = 16'd1000;

    localparam logic [DIV_NUM_W-1:0] RPM_NUMER = 48'd60000000;
    localparam logic [12:0]          DELAY_DEN = 13'd5760;

    // The delay divisor is 128 * 45; the division by 45 is a multiplication by
    // ceil(2^31 / 45) and a shift by 31, exact for dividends below 2^25.
    localparam logic [25:0] DIV45_RECIP = 26'd47721859;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_DELAY = 2'd1;
    localparam logic [1:0] PH_FIRE  = 2'd2;

    typedef struct packed {
        logic        ign;
        logic [15:0] rpm;
        logic [15:0] adv;
        logic [31:0] dly;
        logic        spark;
    } result_t;

endpackage

### hdl/iat_fifo.sv
// Small first-in first-out queue built from registers.
module iat_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = iat_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, rd_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end
endmodule

### hdl/iat_div.sv
// Restoring divider that produces one quotient bit per cycle.
module iat_div #(
    parameter int NUM_W = iat_pkg::DIV_NUM_W,
    parameter int DEN_W = iat_pkg::DIV_DEN_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]   rem_reg;
    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg, done_reg;
    logic [DEN_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg[DEN_W-1:0], quot_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign done  = done_reg;
    assign quot  = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quot_reg <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quot_reg <= num;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? trial - {1'b0, den_reg} : trial;
                quot_reg <= {quot_reg[NUM_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule

### hdl/iat_core.sv
// Tick sequencer: edge timing, phase machine, rpm, advance and delay.
module iat_core #(
    parameter int TABLE_LEN = iat_pkg::TABLE_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [iat_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [iat_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    input  logic                            in_edge,
    output logic                            in_take,
    input  logic                            out_full,
    output logic                            out_push,
    output iat_pkg::result_t                out_data
);
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_RPM_WAIT  = 4'd1;
    localparam logic [3:0] ST_LOOKUP    = 4'd2;
    localparam logic [3:0] ST_MUL       = 4'd3;
    localparam logic [3:0] ST_INT_START = 4'd4;
    localparam logic [3:0] ST_INT_WAIT  = 4'd5;
    localparam logic [3:0] ST_DLY_QUO   = 4'd6;
    localparam logic [3:0] ST_DLY_REM   = 4'd7;
    localparam logic [3:0] ST_DLY_LOW   = 4'd8;
    localparam logic [3:0] ST_DLY_DONE  = 4'd9;

    localparam int NW = iat_pkg::DIV_NUM_W;
    localparam int DW = iat_pkg::DIV_DEN_W;

    logic [63:0] rpm_lo_reg, rpm_hi_reg, adv_lo_reg, adv_hi_reg;
    logic [15:0] pulse_len_reg, min_intv_reg;

    logic [31:0] elapsed_reg, interval_reg, count_reg, last_dly_reg;
    logic        pending_reg;
    logic [1:0]  phase_reg;
    logic [15:0] last_rpm_reg, last_adv_reg;
    logic [3:0]  state_reg;
    logic        ign_reg, spark_reg;
    logic [15:0] rpm_w_reg, adv_w_reg;
    logic [15:0] a0_reg, mag_reg, off_reg, span_reg;
    logic        neg_reg;
    logic [31:0] prod_reg;
    logic [19:0] qi_reg;
    logic [12:0] ri_reg;
    logic [35:0] hiprod_reg;
    logic [28:0] loprod_reg;

    logic [127:0] rpm_all, adv_all;
    logic [15:0] rbin [TABLE_LEN];
    logic [15:0] abin [TABLE_LEN];

    logic        div_start, div_done;
    logic [NW-1:0] div_num, div_quot;
    logic [DW-1:0] div_den;

    logic [31:0] e_inc, intv_c, iv_c, cnt_c;
    logic        accept, pend_c, handle, ign_c, spark_c;
    logic [1:0]  ph_c;
    logic        seg_found;
    logic [15:0] seg_a0, seg_a1, seg_b0, seg_b1;
    logic [31:0] dly_c;
    logic [15:0] int_q;
    logic [50:0] qi_prod;
    logic [32:0] qi_back;
    logic [31:0] ri_full;
    logic [47:0] lo_q_prod;
    logic [36:0] dly_sum;

    assign rpm_all = {rpm_hi_reg, rpm_lo_reg};
    assign adv_all = {adv_hi_reg, adv_lo_reg};

    always_comb
    begin
        for (int i = 0; i < TABLE_LEN; i++)
        begin
            rbin[i] = rpm_all[16*i +: 16];
            abin[i] = adv_all[16*i +: 16];
        end
    end

    always_comb
    begin
        e_inc   = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;
        accept  = in_edge && (e_inc > {16'd0, min_intv_reg});
        intv_c  = accept ? e_inc : interval_reg;
        pend_c  = pending_reg || accept;
        iv_c    = (intv_c == '0) ? 32'd1 : intv_c;
        ph_c    = phase_reg;
        cnt_c   = count_reg;
        ign_c   = 1'b0;
        spark_c = 1'b0;
        handle  = 1'b0;
        if (ph_c == iat_pkg::PH_DELAY)
        begin
            if (cnt_c != '0)
            begin
                cnt_c = cnt_c - 32'd1;
            end
            else
            begin
                cnt_c   = {16'd0, pulse_len_reg};
                ph_c    = (pulse_len_reg == '0) ? iat_pkg::PH_IDLE : iat_pkg::PH_FIRE;
                spark_c = (pulse_len_reg != '0);
            end
        end
        if (ph_c == iat_pkg::PH_FIRE && !(!spark_c && cnt_c == '0))
        begin
            ign_c = 1'b1;
            cnt_c = cnt_c - 32'd1;
            if (cnt_c == '0)
            begin
                ph_c = iat_pkg::PH_IDLE;
            end
        end
        else if (ph_c == iat_pkg::PH_FIRE)
        begin
            ph_c = iat_pkg::PH_IDLE;
        end
        else if (ph_c != iat_pkg::PH_DELAY)
        begin
            ph_c   = iat_pkg::PH_IDLE;
            handle = pend_c;
        end
    end

    always_comb
    begin
        seg_found = 1'b0;
        seg_a0    = abin[0];
        seg_a1    = abin[0];
        seg_b0    = rbin[0];
        seg_b1    = rbin[0];
        for (int i = TABLE_LEN - 2; i >= 0; i--)
        begin
            if (rpm_w_reg >= rbin[i] && rpm_w_reg < rbin[i+1])
            begin
                seg_found = 1'b1;
                seg_a0    = abin[i];
                seg_a1    = abin[i+1];
                seg_b0    = rbin[i];
                seg_b1    = rbin[i+1];
            end
        end
    end

    // The delay is advance * q + (advance * r) / 5760, where q and r are the
    // quotient and remainder of the interval divided by 5760.
    assign qi_prod   = interval_reg[31:7] * iat_pkg::DIV45_RECIP;
    assign qi_back   = qi_reg * iat_pkg::DELAY_DEN;
    assign ri_full   = interval_reg - qi_back[31:0];
    assign lo_q_prod = loprod_reg[28:7] * iat_pkg::DIV45_RECIP;
    assign dly_sum   = {1'b0, hiprod_reg} + {20'd0, lo_q_prod[47:31]};
    assign dly_c     = (dly_sum[36:32] != '0) ? 32'hFFFF_FFFF : dly_sum[31:0];
    assign int_q     = div_quot[15:0];

    always_comb
    begin
        div_start = 1'b0;
        div_num   = iat_pkg::RPM_NUMER;
        div_den   = iv_c;
        unique case (state_reg)
            ST_IDLE:
            begin
                div_start = in_valid && !out_full && handle;
            end
            ST_INT_START:
            begin
                div_start = 1'b1;
                div_num   = {16'd0, prod_reg};
                div_den   = {16'd0, span_reg};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        in_take  = (state_reg == ST_IDLE) && in_valid && !out_full;
        out_push = 1'b0;
        out_data = '{ign: ign_c, rpm: last_rpm_reg, adv: last_adv_reg,
                     dly: last_dly_reg, spark: spark_c};
        if (state_reg == ST_IDLE)
        begin
            out_push = in_take && !handle;
        end
        else if (state_reg == ST_DLY_DONE)
        begin
            out_push = 1'b1;
            out_data = '{ign: ign_reg, rpm: rpm_w_reg, adv: adv_w_reg,
                         dly: dly_c, spark: spark_reg};
        end
    end

    iat_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpm_lo_reg    <= '0;
            rpm_hi_reg    <= '0;
            adv_lo_reg    <= '0;
            adv_hi_reg    <= '0;
            pulse_len_reg <= iat_pkg::PULSE_LEN_RST;
            min_intv_reg  <= iat_pkg::MIN_INTV_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                iat_pkg::REG_RPM_LOW:   rpm_lo_reg    <= cfg_data;
                iat_pkg::REG_RPM_HIGH:  rpm_hi_reg    <= cfg_data;
                iat_pkg::REG_ADV_LOW:   adv_lo_reg    <= cfg_data;
                iat_pkg::REG_ADV_HIGH:  adv_hi_reg    <= cfg_data;
                iat_pkg::REG_PULSE_LEN: pulse_len_reg <= cfg_data[15:0];
                iat_pkg::REG_MIN_INTV:  min_intv_reg  <= cfg_data[15:0];
                default:                rpm_lo_reg    <= rpm_lo_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= '0;
            interval_reg <= '0;
            count_reg    <= '0;
            last_dly_reg <= '0;
            pending_reg  <= 1'b0;
            phase_reg    <= iat_pkg::PH_IDLE;
            last_rpm_reg <= '0;
            last_adv_reg <= '0;
            state_reg    <= ST_IDLE;
            ign_reg      <= 1'b0;
            spark_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        elapsed_reg  <= accept ? 32'd0 : e_inc;
                        interval_reg <= intv_c;
                        phase_reg    <= ph_c;
                        count_reg    <= cnt_c;
                        ign_reg      <= ign_c;
                        spark_reg    <= spark_c;
                        pending_reg  <= pend_c && !handle;
                        if (handle)
                        begin
                            state_reg <= ST_RPM_WAIT;
                        end
                    end
                end
                ST_RPM_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    state_reg <= (rpm_w_reg < rbin[0] || !seg_found) ? ST_DLY_QUO : ST_MUL;
                end
                ST_MUL:        state_reg <= ST_INT_START;
                ST_INT_START:  state_reg <= ST_INT_WAIT;
                ST_INT_WAIT:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DLY_QUO;
                    end
                end
                ST_DLY_QUO:    state_reg <= ST_DLY_REM;
                ST_DLY_REM:    state_reg <= ST_DLY_LOW;
                ST_DLY_LOW:    state_reg <= ST_DLY_DONE;
                ST_DLY_DONE:
                begin
                    last_rpm_reg <= rpm_w_reg;
                    last_adv_reg <= adv_w_reg;
                    last_dly_reg <= dly_c;
                    count_reg    <= dly_c;
                    phase_reg    <= iat_pkg::PH_DELAY;
                    state_reg    <= ST_IDLE;
                end
                default:       state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RPM_WAIT && div_done)
        begin
            rpm_w_reg <= (div_quot[47:16] != '0) ? 16'hFFFF : div_quot[15:0];
        end
        if (state_reg == ST_LOOKUP)
        begin
            a0_reg   <= seg_a0;
            neg_reg  <= (seg_a1 < seg_a0);
            mag_reg  <= (seg_a1 < seg_a0) ? seg_a0 - seg_a1 : seg_a1 - seg_a0;
            off_reg  <= rpm_w_reg - seg_b0;
            span_reg <= seg_b1 - seg_b0;
            if (rpm_w_reg < rbin[0])
            begin
                adv_w_reg <= abin[0];
            end
            else if (!seg_found)
            begin
                adv_w_reg <= abin[TABLE_LEN-1];
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= off_reg * mag_reg;
        end
        if (state_reg == ST_INT_WAIT && div_done)
        begin
            adv_w_reg <= neg_reg ? a0_reg - int_q : a0_reg + int_q;
        end
        if (state_reg == ST_DLY_QUO)
        begin
            qi_reg <= qi_prod[50:31];
        end
        if (state_reg == ST_DLY_REM)
        begin
            ri_reg     <= ri_full[12:0];
            hiprod_reg <= adv_w_reg * qi_reg;
        end
        if (state_reg == ST_DLY_LOW)
        begin
            loprod_reg <= adv_w_reg * ri_reg;
        end
    end
endmodule

### hdl/ignition_advance_timer.sv
// Top level of the ignition advance timer: tick queue, sequencer, result queue.
// A tick with no pulse to handle pushes its result beat in the same cycle it is accepted.
// A tick that handles a pulse pushes its beat only after a pass of the one-bit-per-cycle
// divider for the rpm and, when interpolation is needed, a second pass for it.
// Ticks are worked on one at a time; queues of four beats sit on both sides.
// Reset is asynchronous and active low; it empties both queues and restores
// the register defaults and the idle phase.
module ignition_advance_timer #(
    parameter int TABLE_LEN = iat_pkg::TABLE_LEN_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [iat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iat_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           push,
    output logic                           full,
    input  logic                           falling_edge,
    output logic                           empty,
    input  logic                           pop,
    output logic                           ignition_out,
    output logic [15:0]                    rpm_now,
    output logic [15:0]                    advance_now,
    output logic [31:0]                    delay_now,
    output logic                           spark_start
);
    logic             in_empty, in_take, in_edge;
    logic             out_full, out_push;
    iat_pkg::result_t res_in, res_out;

    iat_fifo #(
        .WIDTH (1),
        .DEPTH (iat_pkg::QUEUE_DEPTH)
    ) u_in_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (falling_edge),
        .full  (full),
        .pop   (in_take),
        .rdata (in_edge),
        .empty (in_empty)
    );

    iat_core #(
        .TABLE_LEN (TABLE_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (!in_empty),
        .in_edge   (in_edge),
        .in_take   (in_take),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_data  (res_in)
    );

    iat_fifo #(
        .WIDTH ($bits(iat_pkg::result_t)),
        .DEPTH (iat_pkg::QUEUE_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (res_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign ignition_out = res_out.ign;
    assign rpm_now      = res_out.rpm;
    assign advance_now  = res_out.adv;
    assign delay_now    = res_out.dly;
    assign spark_start  = res_out.spark;
endmodule

### hdl/iat_checker.sv
// Port-level checks of the ignition advance timer and their bind.
module iat_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        ignition_out,
    input logic        spark_start,
    input logic [31:0] delay_now
);
    a_spark_fires: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && spark_start) |-> ignition_out)
        else $error("spark beat without ignition drive");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(delay_now) && $stable(spark_start)))
        else $error("waiting beat changed");
endmodule

bind ignition_advance_timer iat_checker u_iat_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .empty        (empty),
    .pop          (pop),
    .ignition_out (ignition_out),
    .spark_start  (spark_start),
    .delay_now    (delay_now)
);
